[design/assert_macros.svh]
// Assertion helpers for the design files, included by cau_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/cau_pkg.sv]
`timescale 1ns / 1ps

package cau_pkg;

  // Default number format: Q16.16 in a 32-bit word.
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  // Fixed widths of the request and result fields.
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 2;

  // Depth of the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Operation codes as they arrive on the func port.
  localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NEG = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CMP = 3'd5;

  // Operation classes used by the back end.
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NEG,
    OP_CMP
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  // One classified request as it travels through the queue.
  typedef struct packed {
    op_e                op;
    logic               eq;
    logic [FIELD_W-1:0] a_re;
    logic [FIELD_W-1:0] a_im;
    logic [FIELD_W-1:0] b_re;
    logic [FIELD_W-1:0] b_im;
  } entry_t;

endpackage

[design/cau_front.sv]
`timescale 1ns / 1ps

module cau_front #(
  parameter int unsigned WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
  input  logic                         start,
  input  logic                         full_i,
  input  logic [cau_pkg::FUNC_W-1:0]   func_i,
  input  logic [cau_pkg::FIELD_W-1:0]  a_re_i,
  input  logic [cau_pkg::FIELD_W-1:0]  a_im_i,
  input  logic [cau_pkg::FIELD_W-1:0]  b_re_i,
  input  logic [cau_pkg::FIELD_W-1:0]  b_im_i,
  output logic                         push_o,
  output cau_pkg::entry_t              entry_o
);

  logic signed [WORD_BITS-1:0] a_re_w;
  logic signed [WORD_BITS-1:0] a_im_w;
  logic signed [WORD_BITS-1:0] b_re_w;
  logic signed [WORD_BITS-1:0] b_im_w;
  cau_pkg::op_e                op;

  // A request is taken whenever the queue has room.
  assign push_o = start && !full_i;

  // Only the low word bits of each operand count, taken as signed.
  assign a_re_w = a_re_i[WORD_BITS-1:0];
  assign a_im_w = a_im_i[WORD_BITS-1:0];
  assign b_re_w = b_re_i[WORD_BITS-1:0];
  assign b_im_w = b_im_i[WORD_BITS-1:0];

  // Unused codes behave exactly like compare: zero result, ok status.
  always_comb begin
    case (func_i)
      cau_pkg::FUNC_ADD: op = cau_pkg::OP_ADD;
      cau_pkg::FUNC_SUB: op = cau_pkg::OP_SUB;
      cau_pkg::FUNC_MUL: op = cau_pkg::OP_MUL;
      cau_pkg::FUNC_DIV: op = cau_pkg::OP_DIV;
      cau_pkg::FUNC_NEG: op = cau_pkg::OP_NEG;
      default:           op = cau_pkg::OP_CMP;
    endcase
  end

  // Build the queue entry with sign-extended operands and the equal flag.
  always_comb begin
    entry_o.op   = op;
    entry_o.eq   = (a_re_w == b_re_w) && (a_im_w == b_im_w);
    entry_o.a_re = cau_pkg::FIELD_W'(a_re_w);
    entry_o.a_im = cau_pkg::FIELD_W'(a_im_w);
    entry_o.b_re = cau_pkg::FIELD_W'(b_re_w);
    entry_o.b_im = cau_pkg::FIELD_W'(b_im_w);
  end

endmodule

[design/cau_queue.sv]
`timescale 1ns / 1ps

module cau_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cau_pkg::entry_t wdata_i,
  input  logic            pop_i,
  output cau_pkg::entry_t rdata_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned DEPTH = cau_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cau_pkg::entry_t  fifo_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign rdata_o = fifo_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[design/cau_div.sv]
`timescale 1ns / 1ps

module cau_div #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0][2*WORD_BITS-1:0]   num_i,
  input  logic [1:0]                    neg_i,
  input  logic [2*WORD_BITS-1:0]        den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [1:0][WORD_BITS-1:0]     q_o,
  output logic [1:0]                    big_o,
  output logic [1:0]                    neg_o
);

  localparam int unsigned PW    = 2 * WORD_BITS;
  localparam int unsigned STEPS = PW + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic             run_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PW-1:0]    den_q;

  // One quotient bit per cycle; the last count value presents the result.
  assign busy_o = run_q;
  assign done_o = run_q && (cnt_q == CNT_W'(STEPS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (done_o) begin
      run_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
    end
  end

  // Real and imaginary lanes share the divisor and the step counter.
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [PW-1:0]        num_q;
    logic [PW-1:0]        rem_q, rem_d;
    logic [WORD_BITS-1:0] quo_q, quo_d;
    logic                 big_q, big_d;
    logic                 neg_q;
    logic [PW:0]          shifted;
    logic [PW:0]          diff;
    logic                 ge;

    // Restoring step; the quotient saturates into a sticky flag.
    always_comb begin
      shifted = {rem_q, num_q[PW-1]};
      diff    = shifted - {1'b0, den_q};
      ge      = (shifted >= {1'b0, den_q});
      rem_d   = ge ? diff[PW-1:0] : shifted[PW-1:0];
      quo_d   = {quo_q[WORD_BITS-2:0], ge};
      big_d   = big_q | quo_q[WORD_BITS-1];
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        num_q <= num_i[l];
        rem_q <= '0;
        quo_q <= '0;
        big_q <= 1'b0;
        neg_q <= neg_i[l];
      end else if (run_q && !done_o) begin
        num_q <= {num_q[PW-2:0], 1'b0};
        rem_q <= rem_d;
        quo_q <= quo_d;
        big_q <= big_d;
      end
    end

    assign q_o[l]   = quo_q;
    assign big_o[l] = big_q;
    assign neg_o[l] = neg_q;
  end

endmodule

[design/cau_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cau_back #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  cau_pkg::entry_t               q_rdata_i,
  output logic                          q_pop_o,
  output logic                          done_o,
  output logic [cau_pkg::FIELD_W-1:0]   res_re_o,
  output logic [cau_pkg::FIELD_W-1:0]   res_im_o,
  output logic                          equal_o,
  output logic [cau_pkg::STATUS_W-1:0]  status_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned VW = PW + 1;

  // Saturate a magnitude with sign to the signed word range: {overflow, value}.
  function automatic logic [W:0] sat_mag(input logic [VW-1:0] mag, input logic neg);
    logic [VW-1:0] lim;
    logic [W-1:0]  res;
    logic          ovf;
    lim = neg ? (VW'(1) << (W - 1)) : ((VW'(1) << (W - 1)) - VW'(1));
    ovf = (mag > lim);
    if (ovf) begin
      res = neg ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
    end else begin
      res = neg ? W'(VW'(0) - mag) : mag[W-1:0];
    end
    return {ovf, res};
  endfunction

  logic                div_busy;
  logic                div_done;
  logic                div_start;
  logic                adv;
  logic [1:0][W-1:0]   div_q;
  logic [1:0]          div_big;
  logic [1:0]          div_neg;

  // Stage 1: operands and the six partial products.
  logic                s1_valid_q;
  cau_pkg::op_e        s1_op_q;
  logic                s1_eq_q;
  logic signed [W-1:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;
  logic signed [PW-1:0] p_arbr_q, p_aibi_q, p_arbi_q, p_aibr_q, p_brbr_q, p_bibi_q;
  logic signed [W-1:0] ar, ai, br, bi;

  // Stage 2: combined exact values before scaling and saturation.
  logic                 s2_valid_q;
  cau_pkg::op_e         s2_op_q;
  logic                 s2_eq_q;
  logic signed [VW-1:0] v_re_q, v_re_d, v_im_q, v_im_d;
  logic [PW-1:0]        den_q, den_d;

  logic          neg_re, neg_im;
  logic [VW-1:0] mag_re, mag_im, sh_re, sh_im;
  logic [W:0]    sat_re, sat_im, dsat_re, dsat_im;
  logic          s2_emit;

  // Output register.
  logic                 done_q;
  logic [W-1:0]         res_re_q, res_im_q;
  logic                 eq_q;
  cau_pkg::status_e     status_q;
  logic                 div_eq_q;

  // The whole pipeline holds while the divider owns the result path.
  assign adv     = !div_busy;
  assign q_pop_o = adv && !q_empty_i;

  assign ar = q_rdata_i.a_re[W-1:0];
  assign ai = q_rdata_i.a_im[W-1:0];
  assign br = q_rdata_i.b_re[W-1:0];
  assign bi = q_rdata_i.b_im[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= q_pop_o;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Multiply stage.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q  <= q_rdata_i.op;
      s1_eq_q  <= q_rdata_i.eq;
      s1_ar_q  <= ar;
      s1_ai_q  <= ai;
      s1_br_q  <= br;
      s1_bi_q  <= bi;
      p_arbr_q <= ar * br;
      p_aibi_q <= ai * bi;
      p_arbi_q <= ar * bi;
      p_aibr_q <= ai * br;
      p_brbr_q <= br * br;
      p_bibi_q <= bi * bi;
    end
  end

  // Combine products or operands into the exact result of each part.
  always_comb begin
    v_re_d = '0;
    v_im_d = '0;
    den_d  = $unsigned(p_brbr_q) + $unsigned(p_bibi_q);
    case (s1_op_q)
      cau_pkg::OP_ADD: begin
        v_re_d = VW'(s1_ar_q) + VW'(s1_br_q);
        v_im_d = VW'(s1_ai_q) + VW'(s1_bi_q);
      end
      cau_pkg::OP_SUB: begin
        v_re_d = VW'(s1_ar_q) - VW'(s1_br_q);
        v_im_d = VW'(s1_ai_q) - VW'(s1_bi_q);
      end
      cau_pkg::OP_MUL: begin
        v_re_d = VW'(p_arbr_q) - VW'(p_aibi_q);
        v_im_d = VW'(p_arbi_q) + VW'(p_aibr_q);
      end
      cau_pkg::OP_DIV: begin
        v_re_d = VW'(p_arbr_q) + VW'(p_aibi_q);
        v_im_d = VW'(p_aibr_q) - VW'(p_arbi_q);
      end
      cau_pkg::OP_NEG: begin
        v_re_d = VW'(0) - VW'(s1_ar_q);
        v_im_d = VW'(0) - VW'(s1_ai_q);
      end
      default: begin
        v_re_d = '0;
        v_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_op_q <= s1_op_q;
      s2_eq_q <= s1_eq_q;
      v_re_q  <= v_re_d;
      v_im_q  <= v_im_d;
      den_q   <= den_d;
    end
  end

  // Magnitude, product scaling and saturation.
  always_comb begin
    neg_re = v_re_q[VW-1];
    neg_im = v_im_q[VW-1];
    mag_re = neg_re ? VW'(VW'(0) - v_re_q) : VW'(v_re_q);
    mag_im = neg_im ? VW'(VW'(0) - v_im_q) : VW'(v_im_q);
    sh_re  = (s2_op_q == cau_pkg::OP_MUL) ? (mag_re >> FRAC_BITS) : mag_re;
    sh_im  = (s2_op_q == cau_pkg::OP_MUL) ? (mag_im >> FRAC_BITS) : mag_im;
    sat_re = sat_mag(sh_re, neg_re);
    sat_im = sat_mag(sh_im, neg_im);
  end

  // A divide with a nonzero divisor moves on to the divider.
  assign div_start = adv && s2_valid_q && (s2_op_q == cau_pkg::OP_DIV) && (den_q != '0);
  assign s2_emit   = adv && s2_valid_q && !div_start;

  cau_div #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({mag_im[PW-1:0], mag_re[PW-1:0]}),
    .neg_i   ({neg_im, neg_re}),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .q_o     (div_q),
    .big_o   (div_big),
    .neg_o   (div_neg)
  );

  // A set sticky flag forces the magnitude above the word range.
  assign dsat_re = sat_mag({{(VW - W - 1){1'b0}}, div_big[0], div_q[0]}, div_neg[0]);
  assign dsat_im = sat_mag({{(VW - W - 1){1'b0}}, div_big[1], div_q[1]}, div_neg[1]);

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_eq_q <= s2_eq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_emit || div_done;
    end
  end

  // Result register, loaded from stage 2 or from the divider.
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      res_re_q <= dsat_re[W-1:0];
      res_im_q <= dsat_im[W-1:0];
      eq_q     <= div_eq_q;
      status_q <= (dsat_re[W] || dsat_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else if (s2_emit) begin
      eq_q <= s2_eq_q;
      if (s2_op_q == cau_pkg::OP_DIV) begin
        res_re_q <= '0;
        res_im_q <= '0;
        status_q <= cau_pkg::ST_DIVZ;
      end else begin
        res_re_q <= sat_re[W-1:0];
        res_im_q <= sat_im[W-1:0];
        status_q <= (sat_re[W] || sat_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  assign done_o   = done_q;
  assign res_re_o = cau_pkg::FIELD_W'($signed(res_re_q));
  assign res_im_o = cau_pkg::FIELD_W'($signed(res_im_q));
  assign equal_o  = eq_q;
  assign status_o = status_q;

  // The divider is started only when idle, and is busy right after.
  `ASSERT_PROP(a_div_start_idle, clk_i, rst_ni, div_start |-> !div_busy, "divider restarted")
  `ASSERT_PROP(a_div_busy_after, clk_i, rst_ni, div_start |=> div_busy, "divider not running")
  // Both result sources never load the output register together.
  `ASSERT_NEVER(a_one_source, clk_i, rst_ni, s2_emit && div_done, "result sources collide")
  // The queue is never read past empty.
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop_o && q_empty_i, "pop from empty queue")

endmodule

[design/complex_arith_unit.sv]
`timescale 1ns / 1ps

// Complex arithmetic unit on signed fixed-point operands (Q16.16 by default).
// A request is taken on a clock edge where start is high and busy is low;
// busy rises only when the four-entry request queue is full. Each request
// gives one result, shown for exactly one cycle with done_o high, in request
// order; the receiver cannot stall it. Add, subtract, multiply, negate and
// compare pass the queue, stage 1, stage 2 and the output register, and
// sustain one request per cycle while no divide holds the back end. A divide
// with a nonzero divisor runs in a bit-serial divider that produces one
// quotient bit per cycle and holds the back end until its result is out;
// requests keep queuing meanwhile until the queue fills.
module complex_arith_unit #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [cau_pkg::FUNC_W-1:0]    func_i,
  input  logic [cau_pkg::FIELD_W-1:0]   a_re_i,
  input  logic [cau_pkg::FIELD_W-1:0]   a_im_i,
  input  logic [cau_pkg::FIELD_W-1:0]   b_re_i,
  input  logic [cau_pkg::FIELD_W-1:0]   b_im_i,
  output logic                          done_o,
  output logic [cau_pkg::FIELD_W-1:0]   res_re_o,
  output logic [cau_pkg::FIELD_W-1:0]   res_im_o,
  output logic                          equal_o,
  output logic [cau_pkg::STATUS_W-1:0]  status_o
);

  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;
  cau_pkg::entry_t wr_entry;
  cau_pkg::entry_t rd_entry;

  assign busy = q_full;

  // Front end: take and classify requests.
  cau_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .start   (start),
    .full_i  (q_full),
    .func_i  (func_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .push_o  (push),
    .entry_o (wr_entry)
  );

  // Request queue between front and back end.
  cau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back end: arithmetic pipeline and divider.
  cau_back #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_rdata_i (rd_entry),
    .q_pop_o   (pop),
    .done_o    (done_o),
    .res_re_o  (res_re_o),
    .res_im_o  (res_im_o),
    .equal_o   (equal_o),
    .status_o  (status_o)
  );

endmodule

[bench/complex_arith_unit_tb.sv]
`timescale 1ns / 1ps

module complex_arith_unit_tb;

  localparam int FRAC = cau_pkg::FRAC_BITS_DEF;
  localparam int WORD = cau_pkg::WORD_BITS_DEF;
  localparam longint MAX_POS = (64'sd1 <<< (WORD - 1)) - 1;
  localparam longint MAX_NEG = -(64'sd1 <<< (WORD - 1));
  localparam logic [cau_pkg::FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [cau_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct {
    logic [cau_pkg::FIELD_W-1:0]  re;
    logic [cau_pkg::FIELD_W-1:0]  im;
    logic                         eq;
    logic [cau_pkg::STATUS_W-1:0] st;
  } answer_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [cau_pkg::FUNC_W-1:0]    func_i = '0;
  logic [cau_pkg::FIELD_W-1:0]   a_re_i = '0;
  logic [cau_pkg::FIELD_W-1:0]   a_im_i = '0;
  logic [cau_pkg::FIELD_W-1:0]   b_re_i = '0;
  logic [cau_pkg::FIELD_W-1:0]   b_im_i = '0;
  logic                          done_o;
  logic [cau_pkg::FIELD_W-1:0]   res_re_o;
  logic [cau_pkg::FIELD_W-1:0]   res_im_o;
  logic                          equal_o;
  logic [cau_pkg::STATUS_W-1:0]  status_o;

  answer_t pending_answers[$];
  int      mismatch_count = 0;
  bit      steady_sender = 1'b0;

  complex_arith_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .func_i   (func_i),
    .a_re_i   (a_re_i),
    .a_im_i   (a_im_i),
    .b_re_i   (b_re_i),
    .b_im_i   (b_im_i),
    .done_o   (done_o),
    .res_re_o (res_re_o),
    .res_im_o (res_im_o),
    .equal_o  (equal_o),
    .status_o (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp a wide signed value to the word range and note any clipping.
  function automatic longint clamp_word(logic signed [127:0] v, ref bit clipped);
    if (v > MAX_POS) begin
      clipped = 1'b1;
      return MAX_POS;
    end
    if (v < MAX_NEG) begin
      clipped = 1'b1;
      return MAX_NEG;
    end
    return longint'(v);
  endfunction

  // Fixed-point quotient of a signed numerator by a positive denominator,
  // truncated toward zero.
  function automatic logic signed [127:0] fixed_quotient(logic signed [127:0] num,
                                                         logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FRAC) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Product part scaled back by the fraction bits, truncated toward zero.
  function automatic logic signed [127:0] scale_down(logic signed [127:0] v);
    logic signed [127:0] mag;
    mag = (v < 0) ? -v : v;
    mag = mag >>> FRAC;
    return (v < 0) ? -mag : mag;
  endfunction

  // Expected result of one request.
  function automatic answer_t complex_result(logic [cau_pkg::FUNC_W-1:0] fn,
                                             logic [cau_pkg::FIELD_W-1:0] a_re,
                                             logic [cau_pkg::FIELD_W-1:0] a_im,
                                             logic [cau_pkg::FIELD_W-1:0] b_re,
                                             logic [cau_pkg::FIELD_W-1:0] b_im);
    logic signed [127:0] ar, ai, br, bi, den;
    longint rr, ri;
    bit clipped;
    answer_t ans;
    ar = 128'(signed'(a_re[WORD-1:0]));
    ai = 128'(signed'(a_im[WORD-1:0]));
    br = 128'(signed'(b_re[WORD-1:0]));
    bi = 128'(signed'(b_im[WORD-1:0]));
    rr = 0;
    ri = 0;
    clipped = 1'b0;
    ans.st = cau_pkg::ST_OK;
    case (fn)
      cau_pkg::FUNC_ADD: begin
        rr = clamp_word(ar + br, clipped);
        ri = clamp_word(ai + bi, clipped);
      end
      cau_pkg::FUNC_SUB: begin
        rr = clamp_word(ar - br, clipped);
        ri = clamp_word(ai - bi, clipped);
      end
      cau_pkg::FUNC_MUL: begin
        rr = clamp_word(scale_down(ar * br - ai * bi), clipped);
        ri = clamp_word(scale_down(ar * bi + ai * br), clipped);
      end
      cau_pkg::FUNC_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          ans.st = cau_pkg::ST_DIVZ;
        end else begin
          rr = clamp_word(fixed_quotient(ar * br + ai * bi, den), clipped);
          ri = clamp_word(fixed_quotient(ai * br - ar * bi, den), clipped);
        end
      end
      cau_pkg::FUNC_NEG: begin
        rr = clamp_word(-ar, clipped);
        ri = clamp_word(-ai, clipped);
      end
      default: begin
      end
    endcase
    if (clipped) ans.st = cau_pkg::ST_SAT;
    ans.re = cau_pkg::FIELD_W'(rr);
    ans.im = cau_pkg::FIELD_W'(ri);
    ans.eq = (ar == br) && (ai == bi);
    return ans;
  endfunction

  // Compare every result with the oldest expected one.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result re=%h im=%h", res_re_o, res_im_o);
      end else begin
        want = pending_answers.pop_front();
        if (res_re_o !== want.re || res_im_o !== want.im || equal_o !== want.eq ||
            status_o !== want.st) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected re=%h im=%h eq=%b st=%0d, got re=%h im=%h eq=%b st=%0d",
                     want.re, want.im, want.eq, want.st, res_re_o, res_im_o, equal_o, status_o);
        end
      end
    end
  end

  // Random gaps on the sender side unless a steady stretch is running.
  task automatic sender_gap();
    while (!steady_sender && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Send one request and record its expected result once accepted.
  task automatic send_request(logic [cau_pkg::FUNC_W-1:0] fn,
                              logic [cau_pkg::FIELD_W-1:0] a_re,
                              logic [cau_pkg::FIELD_W-1:0] a_im,
                              logic [cau_pkg::FIELD_W-1:0] b_re,
                              logic [cau_pkg::FIELD_W-1:0] b_im);
    sender_gap();
    start  <= 1'b1;
    func_i <= fn;
    a_re_i <= a_re;
    a_im_i <= a_im;
    b_re_i <= b_re;
    b_im_i <= b_im;
    do @(posedge clk_i); while (busy);
    pending_answers.push_back(complex_result(fn, a_re, a_im, b_re, b_im));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [cau_pkg::FIELD_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'(int'($urandom_range(131072)) - 65536);
      4: return 32'(int'($urandom_range(1 << 24)) - (1 << 23));
      5: return 32'h0001_0000;
      default: return $urandom();
    endcase
  endfunction

  // Extremes of every field, each operation and the named corner cases.
  task automatic test_directed();
    send_request(cau_pkg::FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    send_request(cau_pkg::FUNC_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000);
    send_request(cau_pkg::FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_request(cau_pkg::FUNC_SUB, 32'h1234_5678, 32'h0, 32'h1234_5678, 32'h0);
    send_request(cau_pkg::FUNC_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000);
    send_request(cau_pkg::FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(cau_pkg::FUNC_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(cau_pkg::FUNC_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0);
    send_request(cau_pkg::FUNC_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_request(cau_pkg::FUNC_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_request(cau_pkg::FUNC_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0);
    send_request(cau_pkg::FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(cau_pkg::FUNC_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h0003_0000, 32'hfffd_0000);
    send_request(cau_pkg::FUNC_NEG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_request(cau_pkg::FUNC_NEG, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h0);
    send_request(cau_pkg::FUNC_CMP, 32'h5555_aaaa, 32'haaaa_5555, 32'h5555_aaaa, 32'haaaa_5555);
    send_request(cau_pkg::FUNC_CMP, 32'h5555_aaaa, 32'haaaa_5555, 32'h5555_aaaa, 32'haaaa_5554);
    send_request(FUNC_UNUSED_LO, 32'h0001_0000, 32'h2, 32'h0001_0000, 32'h2);
    send_request(FUNC_UNUSED_HI, 32'hffff_ffff, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
    send_request(cau_pkg::FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  // Random requests, mostly valid codes with some equal operands and zero divisors.
  task automatic test_random(int count);
    logic [cau_pkg::FUNC_W-1:0]  fn;
    logic [cau_pkg::FIELD_W-1:0] ar, ai, br, bi;
    for (int n = 0; n < count; n++) begin
      steady_sender = (n >= count / 2) && (n < count / 2 + 80);
      fn = ($urandom_range(19) == 0) ?
           cau_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO)) :
           cau_pkg::FUNC_W'($urandom_range(cau_pkg::FUNC_CMP));
      ar = pick_value();
      ai = pick_value();
      br = pick_value();
      bi = pick_value();
      case ($urandom_range(9))
        0: begin br = ar; bi = ai; end
        1: begin br = '0; bi = '0; end
        default: begin end
      endcase
      send_request(fn, ar, ai, br, bi);
      if (n == count / 4) drain_results();
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain_results();
    test_random(500);
    drain_results();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit well above the slowest case of all requests dividing.
  initial begin
    #6ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
